>>> sv/sse_pkg.sv
// Shared types and constants of the sparse sub-matrix extraction block.
// No dependencies; compile first.
package sse_pkg;

    // Fixed field widths of the item and result channels
    localparam int OPCODE_W   = 2;
    localparam int IDX_W      = 10;
    localparam int VALUE_W    = 64;
    localparam int PTR_W      = 32;
    localparam int KCOUNT_W   = 11;
    localparam int RANK_W     = 10;

    // Parameter defaults
    localparam int INDEX_DEPTH_DEF = 1024;
    localparam int VALUE_BITS_DEF  = 64;
    localparam int COUNT_BITS_DEF  = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_MARK     = 2'd0,
        OP_RENUMBER = 2'd1,
        OP_ENTRY    = 2'd2,
        OP_CLEAR    = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOKUP,
        ST_WALK,
        ST_REPORT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic idle;          // ready for an item, read port follows the item column
        logic capture;       // latch an entry item
        logic mark_wr;       // set the mark of the item's fine index
        logic sweep_start;   // rewind the cursor for a clearing pass
        logic sweep;         // zero one mark entry, advance cursor
        logic walk_start;    // rewind cursor and rank for a renumber walk
        logic walk_step;     // walk step: advance cursor, rank the pending entry
        logic emit_entry;    // load the entry result, if any
        logic emit_report;   // load the renumber result, zero the counter
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;    // cursor sits on the last mark entry
        logic walk_done;     // all entries read and ranked
        logic out_free;      // output register can take a result this cycle
    } t_status;

endpackage

>>> sv/sse_item_if.sv
// Input item channel: valid/ready handshake with the entry fields.
// Depends on sse_pkg for field widths.
interface sse_item_if;
    import sse_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [IDX_W-1:0]    fine_index;
    logic [IDX_W-1:0]    column;
    logic [VALUE_W-1:0]  value_in;
    logic                last_in_row;
    logic                empty_row;

    modport source (
        output valid, opcode, fine_index, column, value_in, last_in_row, empty_row,
        input  ready
    );
    modport sink (
        input  valid, opcode, fine_index, column, value_in, last_in_row, empty_row,
        output ready
    );
endinterface

>>> sv/sse_result_if.sv
// Result channel: valid/ready handshake with the result fields.
// Depends on sse_pkg for field widths.
interface sse_result_if;
    import sse_pkg::*;

    logic                valid;
    logic                ready;
    logic                kept;
    logic [IDX_W-1:0]    new_column;
    logic [VALUE_W-1:0]  value_out;
    logic [PTR_W-1:0]    position;
    logic                row_end;
    logic [PTR_W-1:0]    row_pointer;
    logic [KCOUNT_W-1:0] kept_count;

    modport source (
        output valid, kept, new_column, value_out, position, row_end, row_pointer,
               kept_count,
        input  ready
    );
    modport sink (
        input  valid, kept, new_column, value_out, position, row_end, row_pointer,
               kept_count,
        output ready
    );
endinterface

>>> sv/sse_ctrl.sv
// Sequencing state machine: clearing pass, item dispatch, walk, result loads.
// Depends on sse_pkg (t_state, t_opcode, t_cmd, t_status).
module sse_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [sse_pkg::OPCODE_W-1:0]   i_opcode,
    input  sse_pkg::t_status               i_status,
    output sse_pkg::t_cmd                  o_cmd
);
    import sse_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_valid) begin
                    case (t_opcode'(i_opcode))
                        OP_MARK: begin
                            o_cmd.mark_wr = 1'b1;
                        end
                        OP_RENUMBER: begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = ST_WALK;
                        end
                        OP_ENTRY: begin
                            o_cmd.capture = 1'b1;
                            n_state       = ST_LOOKUP;
                        end
                        OP_CLEAR: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state           = ST_SWEEP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                if (i_status.out_free) begin
                    o_cmd.emit_entry = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_done) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_report = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_SWEEP;
            end
        endcase
    end

endmodule

>>> sv/sse_datapath.sv
// Mark and rank memories, walk cursor, output counter and result register.
// Depends on sse_pkg and the sse_item_if / sse_result_if interfaces.
module sse_datapath #(
    parameter int INDEX_DEPTH = sse_pkg::INDEX_DEPTH_DEF,
    parameter int VALUE_BITS  = sse_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS  = sse_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sse_pkg::t_cmd      i_cmd,
    output sse_pkg::t_status   o_status,
    sse_item_if.sink           i_item,
    sse_result_if.source       o_result
);
    import sse_pkg::*;

    localparam int IW    = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
    localparam int CW    = $clog2(INDEX_DEPTH + 1);
    localparam int CMP_W = (CW > IDX_W) ? CW : IDX_W;

    // Memories
    logic              r_mark_mem [INDEX_DEPTH];
    logic [RANK_W-1:0] r_rank_mem [INDEX_DEPTH];
    logic              r_rd_mark;
    logic [RANK_W-1:0] r_rd_rank;

    // Walk / sweep control
    logic [CW-1:0]     r_cursor,   n_cursor;
    logic [IW-1:0]     r_cursor_d;
    logic              r_pend,     n_pend;
    logic [CW-1:0]     r_walk_rank, n_walk_rank;
    logic              walk_issue;

    // Captured entry
    logic [IW-1:0]         r_addr;
    logic                  r_in_range;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_last;
    logic                  r_empty;

    // Counter and result register
    logic [COUNT_BITS-1:0] r_counter, n_counter;
    logic                  r_out_valid, n_out_valid;
    logic                  r_kept;
    logic [IDX_W-1:0]      r_new_column;
    logic [VALUE_BITS-1:0] r_value_out;
    logic [PTR_W-1:0]      r_position;
    logic                  r_row_end;
    logic [PTR_W-1:0]      r_row_pointer;
    logic [KCOUNT_W-1:0]   r_kept_count;

    logic [IW-1:0]         rd_addr;
    logic                  col_in_range;
    logic                  fine_in_range;
    logic                  keep;
    logic                  load_entry;
    logic [COUNT_BITS-1:0] counter_inc;

    assign col_in_range  = CMP_W'(i_item.column) < CMP_W'(INDEX_DEPTH);
    assign fine_in_range = CMP_W'(i_item.fine_index) < CMP_W'(INDEX_DEPTH);
    assign walk_issue    = i_cmd.walk_step && (r_cursor != CW'(INDEX_DEPTH));

    always_comb begin
        if (i_cmd.walk_step) begin
            rd_addr = IW'(r_cursor);
        end else if (i_cmd.idle) begin
            rd_addr = IW'(i_item.column);
        end else begin
            rd_addr = r_addr;
        end
    end

    // Mark memory: one write port shared by the sweep and mark items
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_mark_mem[IW'(r_cursor)] <= 1'b0;
        end else if (i_cmd.mark_wr && fine_in_range) begin
            r_mark_mem[IW'(i_item.fine_index)] <= 1'b1;
        end
        r_rd_mark <= r_mark_mem[rd_addr];
    end

    // Rank memory: written by the walk only
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step && r_pend && r_rd_mark) begin
            r_rank_mem[r_cursor_d] <= RANK_W'(r_walk_rank);
        end
        r_rd_rank <= r_rank_mem[rd_addr];
    end

    // Cursor, walk rank and pending read
    always_comb begin
        n_cursor    = r_cursor;
        n_pend      = r_pend;
        n_walk_rank = r_walk_rank;
        if (i_cmd.sweep_start || i_cmd.walk_start) begin
            n_cursor = '0;
        end else if (i_cmd.sweep || walk_issue) begin
            n_cursor = r_cursor + CW'(1);
        end
        if (i_cmd.walk_start) begin
            n_pend      = 1'b0;
            n_walk_rank = '0;
        end else if (i_cmd.walk_step) begin
            n_pend = walk_issue;
            if (r_pend && r_rd_mark) begin
                n_walk_rank = r_walk_rank + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_pend      <= 1'b0;
            r_walk_rank <= '0;
        end else begin
            r_cursor    <= n_cursor;
            r_pend      <= n_pend;
            r_walk_rank <= n_walk_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cursor_d <= IW'(r_cursor);
        if (i_cmd.capture) begin
            r_addr     <= IW'(i_item.column);
            r_in_range <= col_in_range;
            r_value    <= i_item.value_in[VALUE_BITS-1:0];
            r_last     <= i_item.last_in_row;
            r_empty    <= i_item.empty_row;
        end
    end

    // Entry evaluation
    assign keep        = !r_empty && r_in_range && r_rd_mark;
    assign load_entry  = i_cmd.emit_entry && (r_empty || keep || r_last);
    assign counter_inc = (r_counter != '1) ? (r_counter + COUNT_BITS'(1)) : r_counter;

    always_comb begin
        n_counter = r_counter;
        if (i_cmd.emit_report) begin
            n_counter = '0;
        end else if (i_cmd.emit_entry && keep) begin
            n_counter = counter_inc;
        end
        n_out_valid = r_out_valid && !o_result.ready;
        if (load_entry || i_cmd.emit_report) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_counter   <= n_counter;
            r_out_valid <= n_out_valid;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_report) begin
            r_kept        <= 1'b0;
            r_new_column  <= '0;
            r_value_out   <= '0;
            r_position    <= '0;
            r_row_end     <= 1'b0;
            r_row_pointer <= '0;
            r_kept_count  <= KCOUNT_W'(r_walk_rank);
        end else if (load_entry) begin
            r_kept        <= keep;
            r_new_column  <= keep ? IDX_W'(r_rd_rank) : '0;
            r_value_out   <= keep ? r_value : '0;
            r_position    <= keep ? PTR_W'(r_counter) : '0;
            r_row_end     <= r_empty || r_last;
            r_kept_count  <= '0;
            if (r_empty) begin
                r_row_pointer <= PTR_W'(r_counter);
            end else if (r_last) begin
                r_row_pointer <= keep ? PTR_W'(counter_inc) : PTR_W'(r_counter);
            end else begin
                r_row_pointer <= '0;
            end
        end
    end

    assign i_item.ready         = i_cmd.idle;
    assign o_result.valid       = r_out_valid;
    assign o_result.kept        = r_kept;
    assign o_result.new_column  = r_new_column;
    assign o_result.value_out   = VALUE_W'(r_value_out);
    assign o_result.position    = r_position;
    assign o_result.row_end     = r_row_end;
    assign o_result.row_pointer = r_row_pointer;
    assign o_result.kept_count  = r_kept_count;

    assign o_status.sweep_last = (r_cursor == CW'(INDEX_DEPTH - 1));
    assign o_status.walk_done  = (r_cursor == CW'(INDEX_DEPTH)) && !r_pend;
    assign o_status.out_free   = !r_out_valid || o_result.ready;

endmodule

>>> sv/sparse_submatrix_extract_core.sv
// Top level of the CSR sub-matrix extraction block.
// Depends on sse_pkg, sse_item_if, sse_result_if, sse_ctrl and sse_datapath.
//
// Selects a sub-matrix of a CSR sparse matrix. Mark transactions flag a fine
// index as kept; a renumber transaction walks the mark memory in index order,
// stores each kept index's exclusive-prefix rank, zeroes the output counter
// and returns the kept count; entry transactions (column, value, row-end and
// empty-row flags of a selected row) return the compact column, the value
// and the output slot of a kept entry, and the next row pointer at a row end.
// Entries whose column is not kept and that do not end a row return nothing.
// The output counter saturates at its largest value. Steps: a mark is written
// as it is accepted; an entry is accepted, then the mark and rank memories
// are read at the column through a register, then the result is loaded after
// any wait on the result port; a renumber is the accept, the walk reading one
// mark entry a cycle, ranking the last entry and seeing the walk end, and the
// result load after any wait on the result port; a clear is the accept and a
// pass that zeroes the mark memory one entry a cycle. After reset the same
// pass runs before the first transaction is accepted. The result sits in an
// output register, so a new item is accepted while a result still waits to be
// taken. A compact column is only meaningful for an index that was marked
// before the last renumber.
module sparse_submatrix_extract_core #(
    parameter int INDEX_DEPTH = sse_pkg::INDEX_DEPTH_DEF,
    parameter int VALUE_BITS  = sse_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS  = sse_pkg::COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sse_item_if.sink      i_item,
    sse_result_if.source  o_result
);
    import sse_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencing: sweep after reset, dispatch by opcode, walk, result loads
    sse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_item.valid),
        .i_opcode (i_item.opcode),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Memories, counters and the result register
    sse_datapath #(
        .INDEX_DEPTH (INDEX_DEPTH),
        .VALUE_BITS  (VALUE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for sparse_submatrix_extract_core.
// Depends on sse_pkg, sse_item_if, sse_result_if and the core RTL; compile last.
// Directed table first, then random mark/renumber/row phases checked by a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sse_pkg::*;

    localparam int DEPTH       = INDEX_DEPTH_DEF;
    localparam int VBITS       = VALUE_BITS_DEF;
    localparam int CBITS       = COUNT_BITS_DEF;
    localparam int IDLE_PCT    = 36;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 1150;
    localparam int CALM_FROM   = 1300;
    localparam int CALM_TO     = 1650;
    localparam int ITEM_TARGET = 1950;
    localparam int DRAIN_LIMIT = 50000;
    localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VBITS);

    typedef struct packed {
        t_opcode            op;
        logic [IDX_W-1:0]   fine_index;
        logic [IDX_W-1:0]   column;
        logic [VALUE_W-1:0] value_in;
        logic               last_in_row;
        logic               empty_row;
    } t_item;

    typedef struct packed {
        logic                kept;
        logic [IDX_W-1:0]    new_column;
        logic [VALUE_W-1:0]  value_out;
        logic [PTR_W-1:0]    position;
        logic                row_end;
        logic [PTR_W-1:0]    row_pointer;
        logic [KCOUNT_W-1:0] kept_count;
    } t_result;

    typedef struct packed {
        t_item   it;
        logic    typed;
        logic    has_res;
        t_result res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    sse_item_if   item_if ();
    sse_result_if result_if ();

    sparse_submatrix_extract_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    // Predictor state: marks, ranks of the last walk, output counter
    bit                 mark_q   [DEPTH];
    logic [RANK_W-1:0]  rank_q   [DEPTH];
    bit                 rank_set [DEPTH];
    logic [CBITS-1:0]   out_cnt;
    int unsigned        marked_list [$];

    t_result     expected_q [$];
    t_row        dir_rows [$];
    int          err_count = 0;
    int          n_sent    = 0;
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;
    bit          calm      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_item mk_item(t_opcode op, logic [IDX_W-1:0] fidx,
                                      logic [IDX_W-1:0] col, logic [VALUE_W-1:0] val,
                                      logic last, logic empty);
        t_item it;
        it.op          = op;
        it.fine_index  = fidx;
        it.column      = col;
        it.value_in    = val;
        it.last_in_row = last;
        it.empty_row   = empty;
        return it;
    endfunction

    function automatic t_result mk_res(logic kept, logic [IDX_W-1:0] ncol,
                                       logic [VALUE_W-1:0] val, logic [PTR_W-1:0] pos,
                                       logic rend, logic [PTR_W-1:0] rptr,
                                       logic [KCOUNT_W-1:0] kcnt);
        t_result r;
        r.kept        = kept;
        r.new_column  = ncol;
        r.value_out   = val;
        r.position    = pos;
        r.row_end     = rend;
        r.row_pointer = rptr;
        r.kept_count  = kcnt;
        return r;
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.op          = t_opcode'($urandom_range(3, 0));
        it.fine_index  = IDX_W'($urandom_range(DEPTH - 1, 0));
        it.column      = IDX_W'($urandom_range(DEPTH - 1, 0));
        it.value_in    = {$urandom, $urandom};
        it.last_in_row = 1'($urandom_range(1, 0));
        it.empty_row   = 1'($urandom_range(1, 0));
        return it;
    endfunction

    task automatic row_typed(input t_item it, input logic has, input t_result r);
        dir_rows.push_back('{it, 1'b1, has, r});
    endtask

    task automatic row_checked(input t_item it);
        dir_rows.push_back('{it, 1'b0, 1'b0, '0});
    endtask

    // Work out the result of one accepted transaction and advance the state
    task automatic predict_extract(input t_item it, output logic has, output t_result r);
        int  rank_cnt;
        bit  take;
        r   = '0;
        has = 1'b0;
        case (it.op)
            OP_MARK: begin
                if (it.fine_index < DEPTH) begin
                    if (!mark_q[it.fine_index]) marked_list.push_back(it.fine_index);
                    mark_q[it.fine_index] = 1'b1;
                end
            end
            OP_RENUMBER: begin
                rank_cnt = 0;
                for (int i = 0; i < DEPTH; i++) begin
                    if (mark_q[i]) begin
                        rank_q[i]   = rank_cnt[RANK_W-1:0];
                        rank_set[i] = 1'b1;
                        rank_cnt++;
                    end
                end
                out_cnt      = '0;
                r.kept_count = rank_cnt[KCOUNT_W-1:0];
                has          = 1'b1;
            end
            OP_CLEAR: begin
                foreach (mark_q[i]) mark_q[i] = 1'b0;
                marked_list.delete();
            end
            default: begin
                if (it.empty_row) begin
                    r.row_end     = 1'b1;
                    r.row_pointer = out_cnt[PTR_W-1:0];
                    has           = 1'b1;
                end else begin
                    take = (it.column < DEPTH) && mark_q[it.column];
                    if (take) begin
                        r.kept       = 1'b1;
                        r.new_column = rank_q[it.column];
                        r.value_out  = it.value_in & VALUE_MASK;
                        r.position   = out_cnt[PTR_W-1:0];
                        // counter sticks at its largest value
                        if (out_cnt != {CBITS{1'b1}}) out_cnt = out_cnt + 1'b1;
                    end
                    if (it.last_in_row) begin
                        r.row_end     = 1'b1;
                        r.row_pointer = out_cnt[PTR_W-1:0];
                    end
                    has = take || it.last_in_row;
                end
            end
        endcase
    endtask

    // Offer one transaction, hold it until accepted, then record its expectation
    task automatic offer_item(input t_item it, input logic typed, input logic typed_has,
                              input t_result typed_res);
        logic    has;
        t_result r;
        // never look up a rank that no walk has written
        if (it.op == OP_ENTRY && !it.empty_row && mark_q[it.column] && !rank_set[it.column])
            it.empty_row = 1'b1;
        if (!hold_req && n_sent >= HOLD_AT && it.op == OP_ENTRY) hold_req = 1'b1;
        calm = (n_sent >= CALM_FROM) && (n_sent < CALM_TO);
        while (!calm && !(hold_req && !hold_done) && $urandom_range(99, 0) < IDLE_PCT) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid       <= 1'b1;
        item_if.opcode      <= it.op;
        item_if.fine_index  <= it.fine_index;
        item_if.column      <= it.column;
        item_if.value_in    <= it.value_in;
        item_if.last_in_row <= it.last_in_row;
        item_if.empty_row   <= it.empty_row;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        n_sent++;
        predict_extract(it, has, r);
        if (typed) begin
            has = typed_has;
            r   = typed_res;
        end
        if (has) expected_q.push_back(r);
    endtask

    task automatic check_result(input t_result exp_r, input t_result act);
        if (act.kept !== exp_r.kept) begin
            $error("kept: expected %0d, got %0d", exp_r.kept, act.kept);
            err_count++;
        end
        if (act.new_column !== exp_r.new_column) begin
            $error("new_column: expected %0d, got %0d", exp_r.new_column, act.new_column);
            err_count++;
        end
        if (act.value_out !== exp_r.value_out) begin
            $error("value_out: expected %h, got %h", exp_r.value_out, act.value_out);
            err_count++;
        end
        if (act.position !== exp_r.position) begin
            $error("position: expected %0d, got %0d", exp_r.position, act.position);
            err_count++;
        end
        if (act.row_end !== exp_r.row_end) begin
            $error("row_end: expected %0d, got %0d", exp_r.row_end, act.row_end);
            err_count++;
        end
        if (act.row_pointer !== exp_r.row_pointer) begin
            $error("row_pointer: expected %0d, got %0d", exp_r.row_pointer, act.row_pointer);
            err_count++;
        end
        if (act.kept_count !== exp_r.kept_count) begin
            $error("kept_count: expected %0d, got %0d", exp_r.kept_count, act.kept_count);
            err_count++;
        end
    endtask

    // Result receiver: random back-pressure, one long hold-off on request
    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    result_if.ready <= 1'b0;
                    @(posedge i_clk);
                end
                hold_done = 1'b1;
            end
            result_if.ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result act;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            act.kept        = result_if.kept;
            act.new_column  = result_if.new_column;
            act.value_out   = result_if.value_out;
            act.position    = result_if.position;
            act.row_end     = result_if.row_end;
            act.row_pointer = result_if.row_pointer;
            act.kept_count  = result_if.kept_count;
            if (expected_q.size() == 0) begin
                $error("result with no expectation pending: kept=%0d row_end=%0d count=%0d",
                       act.kept, act.row_end, act.kept_count);
                err_count++;
            end else begin
                check_result(expected_q.pop_front(), act);
            end
        end
    end

    initial begin : stimulus
        t_item it;
        int    perm [DEPTH];
        int    phase;
        int    n_marks;
        int    base;
        int    n_rows;
        int    n_ent;
        int    j;
        int    tmp;
        int    waited;

        i_rst_n             <= 1'b0;
        item_if.valid       <= 1'b0;
        item_if.opcode      <= OP_MARK;
        item_if.fine_index  <= '0;
        item_if.column      <= '0;
        item_if.value_in    <= '0;
        item_if.last_in_row <= 1'b0;
        item_if.empty_row   <= 1'b0;
        foreach (mark_q[i]) begin
            mark_q[i]   = 1'b0;
            rank_set[i] = 1'b0;
            rank_q[i]   = '0;
        end
        out_cnt = '0;

        // Directed table: typed results where they follow at a glance
        row_typed(mk_item(OP_RENUMBER, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0));
        row_typed(mk_item(OP_ENTRY, 1023, 0, '1, 0, 0), 1'b0, '0);
        row_typed(mk_item(OP_ENTRY, 0, 1023, '1, 1, 0), 1'b1, mk_res(0, 0, 0, 0, 1, 0, 0));
        row_typed(mk_item(OP_ENTRY, 0, 5, '1, 1, 1), 1'b1, mk_res(0, 0, 0, 0, 1, 0, 0));
        row_typed(mk_item(OP_MARK, 0, 1023, '1, 1, 1), 1'b0, '0);
        row_typed(mk_item(OP_MARK, 1023, 0, 0, 0, 0), 1'b0, '0);
        row_typed(mk_item(OP_MARK, 512, 0, 0, 0, 0), 1'b0, '0);
        row_typed(mk_item(OP_MARK, 512, 0, 0, 0, 0), 1'b0, '0);
        row_typed(mk_item(OP_RENUMBER, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 0, 0, 3));
        row_typed(mk_item(OP_ENTRY, 0, 0, '1, 0, 0), 1'b1, mk_res(1, 0, '1, 0, 0, 0, 0));
        row_typed(mk_item(OP_ENTRY, 0, 1023, 0, 1, 0), 1'b1, mk_res(1, 2, 0, 1, 1, 2, 0));
        row_typed(mk_item(OP_ENTRY, 0, 512, 64'hA5A5_5A5A_0F0F_F0F0, 0, 0), 1'b1,
                  mk_res(1, 1, 64'hA5A5_5A5A_0F0F_F0F0, 2, 0, 0, 0));
        row_typed(mk_item(OP_ENTRY, 0, 7, '1, 0, 0), 1'b0, '0);
        row_typed(mk_item(OP_ENTRY, 0, 1023, '1, 0, 1), 1'b1, mk_res(0, 0, 0, 0, 1, 3, 0));
        row_typed(mk_item(OP_CLEAR, 0, 0, 0, 0, 0), 1'b0, '0);
        row_typed(mk_item(OP_ENTRY, 0, 0, '1, 1, 0), 1'b1, mk_res(0, 0, 0, 0, 1, 3, 0));
        row_typed(mk_item(OP_MARK, 1023, 0, 0, 0, 0), 1'b0, '0);
        // marked again after a clear: the rank from the earlier walk still answers
        row_checked(mk_item(OP_ENTRY, 0, 1023, 64'h0123_4567_89AB_CDEF, 1, 0));
        row_checked(mk_item(OP_MARK, 3, 0, 0, 0, 0));
        row_checked(mk_item(OP_RENUMBER, 0, 0, 0, 0, 0));
        row_checked(mk_item(OP_ENTRY, 0, 3, 64'hFEDC_BA98_7654_3210, 0, 0));
        row_checked(mk_item(OP_ENTRY, 0, 1023, 64'h8000_0000_0000_0001, 1, 0));
        row_checked(mk_item(OP_ENTRY, 0, 0, 0, 0, 1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            offer_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].has_res, dir_rows[i].res);

        // Random phases: optional clear, marks, renumber, then rows of entries
        phase = 0;
        while (n_sent < ITEM_TARGET) begin
            if (phase != 2 && $urandom_range(2, 0) == 0) begin
                it    = random_item();
                it.op = OP_CLEAR;
                offer_item(it, 1'b0, 1'b0, '0);
            end
            if (phase == 2) begin
                // dense phase: mark every index in shuffled order
                for (int i = 0; i < DEPTH; i++) perm[i] = i;
                for (int i = DEPTH - 1; i > 0; i--) begin
                    j       = $urandom_range(i, 0);
                    tmp     = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                for (int i = 0; i < DEPTH; i++) begin
                    it            = random_item();
                    it.op         = OP_MARK;
                    it.fine_index = IDX_W'(perm[i]);
                    offer_item(it, 1'b0, 1'b0, '0);
                end
            end else begin
                n_marks = $urandom_range(40, 0);
                base    = $urandom_range(DEPTH - 1, 0);
                for (int k = 0; k < n_marks; k++) begin
                    it    = random_item();
                    it.op = OP_MARK;
                    if ($urandom_range(3, 0) == 0)
                        it.fine_index = IDX_W'((base + $urandom_range(15, 0)) % DEPTH);
                    offer_item(it, 1'b0, 1'b0, '0);
                end
            end
            it    = random_item();
            it.op = OP_RENUMBER;
            offer_item(it, 1'b0, 1'b0, '0);

            n_rows = $urandom_range(8, 1);
            for (int rw = 0; rw < n_rows; rw++) begin
                if ($urandom_range(7, 0) == 0) begin
                    it           = random_item();
                    it.op        = OP_ENTRY;
                    it.empty_row = 1'b1;
                    offer_item(it, 1'b0, 1'b0, '0);
                end else begin
                    n_ent = $urandom_range(10, 1);
                    for (int e = 0; e < n_ent; e++) begin
                        it             = random_item();
                        it.op          = OP_ENTRY;
                        it.empty_row   = 1'b0;
                        it.last_in_row = (e == n_ent - 1);
                        // mostly kept columns, the rest random
                        if (marked_list.size() != 0 && $urandom_range(9, 0) < 6)
                            it.column = IDX_W'(marked_list[$urandom_range(marked_list.size() - 1, 0)]);
                        offer_item(it, 1'b0, 1'b0, '0);
                        // drop in an occasional unrelated transaction
                        if ($urandom_range(24, 0) == 0)
                            offer_item(random_item(), 1'b0, 1'b0, '0);
                    end
                end
            end
            phase++;
        end

        item_if.valid <= 1'b0;

        // Drain: wait for outstanding results, then cover a full walk or clear
        waited = 0;
        while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DEPTH + 16) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/sse_pkg.sv
sv/sse_item_if.sv
sv/sse_result_if.sv
sv/sse_ctrl.sv
sv/sse_datapath.sv
sv/sparse_submatrix_extract_core.sv
tb/sv/tb.sv
